[rtl/core/hid_to_ps2_scancode_translator_defines.svh]
// Assertion helpers for the translator RTL.
`ifndef HID_TO_PS2_SCANCODE_TRANSLATOR_DEFINES_SVH
`define HID_TO_PS2_SCANCODE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define H2PS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h2ps check failed");

// Next-cycle implication, disabled during reset.
`define H2PS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h2ps check failed");

`endif

[rtl/core/h2ps_pkg.sv]
package h2ps_pkg;

   localparam logic [15:0] HidPageKeyboard = 16'h0007;
   localparam logic [15:0] ModFirst        = 16'h00E0;
   localparam logic [15:0] ModLast         = 16'h00E7;
   localparam logic [7:0]  BreakBit        = 8'h80;
   localparam logic [7:0]  PrefixByte      = 8'hE0;
   localparam int          KeyTableEntries = 83;

   localparam logic [1:0]  ReportArray     = 2'd0;
   localparam logic [1:0]  ReportVariable  = 2'd1;

   localparam logic [15:0] KeyCodes [KeyTableEntries] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
      16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
      16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
      16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
      16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
      16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
      16'h001b, 16'h002b, 16'h002b, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
      16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
      16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
      16'he046, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
      16'he04b, 16'he050, 16'he048
   };

   localparam logic [15:0] ModCodes [8] = '{
      16'h001d, 16'h002a, 16'h0038, 16'he05b,
      16'he01d, 16'h0036, 16'he038, 16'he05c
   };

   // Translated result of one event: up to two bytes.
   typedef struct packed {
      logic       emit;
      logic       prefix;
      logic       event_kind;
      logic [7:0] code;
   } xlate_type;

endpackage

[rtl/core/h2ps_xlate.sv]
module h2ps_xlate #(
   parameter int TABLE_ENTRIES = 83
) (
   input  logic [15:0]          hid_page,
   input  logic [15:0]          usage,
   input  logic [1:0]           report_kind,
   input  logic                 pressed,
   input  logic [7:0]           mod_state,
   output h2ps_pkg::xlate_type  xlate,
   output logic [7:0]           mod_next
);
   import h2ps_pkg::*;

   logic        page_ok;
   logic        is_mod;
   logic [2:0]  mod_idx;
   logic        mod_was;
   logic [7:0]  idx;
   logic        idx_ok;
   logic [15:0] key_code;
   logic [15:0] mod_code;
   logic [15:0] sel_code;
   logic        release_evt;

   assign page_ok  = (hid_page == HidPageKeyboard);
   assign is_mod   = (report_kind == ReportVariable) && (usage >= ModFirst) &&
                     (usage <= ModLast);
   assign mod_idx  = usage[2:0];
   assign mod_was  = mod_state[mod_idx];
   assign idx      = usage[7:0];
   assign idx_ok   = ({1'b0, idx} < 9'(TABLE_ENTRIES)) &&
                     ({1'b0, idx} < 9'(KeyTableEntries));
   assign key_code = idx_ok ? KeyCodes[idx[6:0]] : 16'h0000;
   assign mod_code = ModCodes[mod_idx];
   assign sel_code = is_mod ? mod_code : key_code;
   assign release_evt = ~pressed;

   always_comb begin
      mod_next = mod_state;
      if (page_ok && is_mod) begin
         mod_next[mod_idx] = pressed;
      end
   end

   always_comb begin
      xlate.prefix     = (sel_code[15:8] != 8'h00);
      xlate.event_kind = release_evt;
      xlate.code       = sel_code[7:0] | (release_evt ? BreakBit : 8'h00);
      xlate.emit       = 1'b0;
      if (page_ok) begin
         if (is_mod) begin
            xlate.emit = (pressed != mod_was);
         end else if (report_kind == ReportArray || report_kind == ReportVariable) begin
            xlate.emit = idx_ok;
         end
      end
   end

endmodule

[rtl/core/hid_to_ps2_scancode_translator.sv]
// HID keyboard event to PS/2 set-1 scancode translator. Each accepted event
// lands in an input register, is translated by one level of table and compare
// logic, and is loaded into a result register that sends its bytes on the rsp
// channel: the 0xE0 prefix beat (rsp_last low) first for two-byte codes, then
// the code beat with rsp_last high. The result register emits one beat per
// cycle while rsp_ready is high; events that produce nothing (other pages,
// other report kinds, usages past the table, unchanged modifiers) retire
// without loading it. The first beat becomes valid once the event has passed
// through the input register and then the result register. Modifier state
// (E0..E7, variable reports) clears on reset.
`include "hid_to_ps2_scancode_translator_defines.svh"

module hid_to_ps2_scancode_translator #(
   parameter int TABLE_ENTRIES = 83
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_hid_page,
   input  logic [15:0] req_usage,
   input  logic [1:0]  req_report_kind,
   input  logic        req_pressed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_kind,
   output logic [7:0]  rsp_scan_byte,
   output logic        rsp_last
);
   import h2ps_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_page_ff, in_usage_ff;
   logic [1:0]  in_kind_ff;
   logic        in_pressed_ff;
   logic [7:0]  mod_ff, mod_in;
   logic [7:0]  mod_next;
   xlate_type   xlate;

   logic        out_valid_ff, out_valid_in;
   logic        out_prefix_ff, out_prefix_in;
   logic        out_kind_ff;
   logic [7:0]  out_code_ff;

   logic        req_take;
   logic        rsp_take;
   logic        out_done;
   logic        out_free;
   logic        s1_adv;
   logic        out_load;
   logic        prefix_take;
   logic        code_beat;

   h2ps_xlate #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_xlate (
      .hid_page    (in_page_ff),
      .usage       (in_usage_ff),
      .report_kind (in_kind_ff),
      .pressed     (in_pressed_ff),
      .mod_state   (mod_ff),
      .xlate       (xlate),
      .mod_next    (mod_next)
   );

   assign rsp_take = rsp_valid && rsp_ready;
   assign out_done = rsp_take && !out_prefix_ff;
   assign out_free = !out_valid_ff || out_done;
   assign s1_adv   = in_valid_ff && (!xlate.emit || out_free);
   assign out_load = s1_adv && xlate.emit;
   assign req_ready = !in_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_scan_byte  = out_prefix_ff ? PrefixByte : out_code_ff;
   assign rsp_last       = !out_prefix_ff;

   assign prefix_take = rsp_take && !rsp_last;
   assign code_beat   = rsp_valid && rsp_last;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (s1_adv) begin
         in_valid_in = 1'b0;
      end
      mod_in = s1_adv ? mod_next : mod_ff;
      out_valid_in  = out_valid_ff;
      out_prefix_in = out_prefix_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_prefix_in = xlate.prefix;
      end else if (out_done) begin
         out_valid_in = 1'b0;
      end else if (rsp_take) begin
         // prefix beat gone, code beat next
         out_prefix_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mod_ff        <= 8'h00;
         out_valid_ff  <= 1'b0;
         out_prefix_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mod_ff        <= mod_in;
         out_valid_ff  <= out_valid_in;
         out_prefix_ff <= out_prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_page_ff    <= req_hid_page;
         in_usage_ff   <= req_usage;
         in_kind_ff    <= req_report_kind;
         in_pressed_ff <= req_pressed;
      end
      if (out_load) begin
         out_kind_ff <= xlate.event_kind;
         out_code_ff <= xlate.code;
      end
   end

   // a prefix beat is always followed by its code beat of the same kind
   `H2PS_ASSERT_NEXT(a_prefix_code, clock, reset, prefix_take, code_beat && $stable(rsp_event_kind))
   // modifier state moves only when the held event retires
   `H2PS_ASSERT_NEXT(a_mod_hold, clock, reset, !s1_adv, $stable(mod_ff))
   // a modifier change always produces a make or break
   `H2PS_ASSERT_IMPLY(a_mod_change_emits, clock, reset, s1_adv && mod_next != mod_ff, xlate.emit)

endmodule

[tb/hid_to_ps2_scancode_translator_tb.sv]
module hid_to_ps2_scancode_translator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import h2ps_pkg::*;

   localparam int TableEntries = 83;
   localparam logic [1:0] ReportOther    = 2'd2;
   localparam logic [1:0] ReportReserved = 2'd3;

   // set-1 codes by keyboard usage; upper byte nonzero means a 0xE0 prefix
   localparam logic [15:0] Set1KeyCode [TableEntries] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
      16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
      16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
      16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
      16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
      16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
      16'h001b, 16'h002b, 16'h002b, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
      16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
      16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
      16'he046, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
      16'he04b, 16'he050, 16'he048
   };

   localparam logic [15:0] Set1ModCode [8] = '{
      16'h001d, 16'h002a, 16'h0038, 16'he05b,
      16'he01d, 16'h0036, 16'he038, 16'he05c
   };

   typedef struct packed {
      logic       event_kind;
      logic [7:0] scan_byte;
      logic       last;
   } scan_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_hid_page = '0;
   logic [15:0] req_usage = '0;
   logic [1:0]  req_report_kind = '0;
   logic        req_pressed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_event_kind;
   logic [7:0]  rsp_scan_byte;
   logic        rsp_last;

   scan_beat_type expected_scan_beats[$];
   logic [7:0]    modifier_held = '0;
   int            error_count = 0;
   bit            req_idle_on = 1'b1;
   bit            rsp_idle_on = 1'b1;
   int            hold_off_cycles = 0;

   hid_to_ps2_scancode_translator #(
      .TABLE_ENTRIES(TableEntries)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hid_page   (req_hid_page),
      .req_usage      (req_usage),
      .req_report_kind(req_report_kind),
      .req_pressed    (req_pressed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_scan_byte  (rsp_scan_byte),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("[hid_to_ps2_scancode_translator] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void push_scan_code(input logic [15:0] code, input logic is_break);
      logic [15:0]   c;
      scan_beat_type beat;
      c = code;
      if (is_break) c = c | {8'h00, BreakBit};
      if (c[15:8] != 8'h00) begin
         beat.event_kind = is_break;
         beat.scan_byte  = PrefixByte;
         beat.last       = 1'b0;
         expected_scan_beats.push_back(beat);
      end
      beat.event_kind = is_break;
      beat.scan_byte  = c[7:0];
      beat.last       = 1'b1;
      expected_scan_beats.push_back(beat);
   endfunction

   function automatic void push_key(input logic [15:0] usage, input logic pressed);
      if (int'(usage[7:0]) >= TableEntries) return;
      push_scan_code(Set1KeyCode[usage[6:0]], !pressed);
   endfunction

   function automatic void translate_event(input logic [15:0] page, input logic [15:0] usage,
                                           input logic [1:0] kind, input logic pressed);
      logic [2:0] m;
      if (page != HidPageKeyboard) return;
      if (kind == ReportArray) begin
         push_key(usage, pressed);
      end else if (kind == ReportVariable) begin
         if (usage >= ModFirst && usage <= ModLast) begin
            m = usage[2:0];
            // only a change of state produces a make or break
            if (!pressed && modifier_held[m]) push_scan_code(Set1ModCode[m], 1'b1);
            else if (pressed && !modifier_held[m]) push_scan_code(Set1ModCode[m], 1'b0);
            modifier_held[m] = pressed;
         end else begin
            push_key(usage, pressed);
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic int pick_gap();
      int roll;
      if (!req_idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // valid is only lowered when a gap follows, so back-to-back events keep it high
   task automatic send_event(input logic [15:0] page, input logic [15:0] usage,
                             input logic [1:0] kind, input logic pressed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_hid_page    <= page;
      req_usage       <= usage;
      req_report_kind <= kind;
      req_pressed     <= pressed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      translate_event(page, usage, kind, pressed);
   endtask

   task automatic test_directed_cases();
      send_event(16'h0000, 16'h0004, ReportArray, 1'b1);       // other page
      send_event(16'hFFFF, 16'h0004, ReportArray, 1'b1);
      send_event(16'h0107, 16'h0004, ReportVariable, 1'b1);
      send_event(HidPageKeyboard, 16'h0004, ReportOther, 1'b1);
      send_event(HidPageKeyboard, 16'h0004, ReportReserved, 1'b0);
      send_event(HidPageKeyboard, 16'h0000, ReportArray, 1'b1);  // reserved entry, code 0
      send_event(HidPageKeyboard, 16'h0003, ReportArray, 1'b0);
      send_event(HidPageKeyboard, 16'h0004, ReportArray, 1'b1);
      send_event(HidPageKeyboard, 16'd82, ReportArray, 1'b1);    // last entry, two bytes
      send_event(HidPageKeyboard, 16'd82, ReportArray, 1'b0);
      send_event(HidPageKeyboard, 16'd83, ReportArray, 1'b1);    // past the table
      send_event(HidPageKeyboard, 16'hFFFF, ReportArray, 1'b0);
      send_event(HidPageKeyboard, 16'hFF04, ReportArray, 1'b0);  // high byte ignored
      send_event(HidPageKeyboard, 16'h0046, ReportVariable, 1'b1);
      send_event(HidPageKeyboard, 16'h01E0, ReportVariable, 1'b1); // not a modifier
      send_event(HidPageKeyboard, 16'h00E1, ReportArray, 1'b1);  // modifier in array report
      send_event(HidPageKeyboard, ModFirst, ReportVariable, 1'b1);
      send_event(HidPageKeyboard, ModFirst, ReportVariable, 1'b1); // no change
      send_event(HidPageKeyboard, ModFirst, ReportVariable, 1'b0);
      send_event(HidPageKeyboard, ModFirst, ReportVariable, 1'b0);
      send_event(HidPageKeyboard, 16'h00E5, ReportVariable, 1'b1); // right shift
      send_event(HidPageKeyboard, ModLast, ReportVariable, 1'b1);
      send_event(HidPageKeyboard, ModLast, ReportVariable, 1'b0);
      send_event(HidPageKeyboard, 16'h00E5, ReportVariable, 1'b0);
      send_event(HidPageKeyboard, 16'h00E3, ReportVariable, 1'b0); // never held
   endtask

   task automatic test_output_stall();
      req_idle_on = 1'b0;
      hold_off_cycles = 120;
      for (int i = 0; i < 30; i++) begin
         send_event(HidPageKeyboard, 16'($urandom_range(70, 82)), ReportArray,
                    1'($urandom_range(0, 1)));
      end
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_events(input int count);
      int          roll;
      logic [15:0] page;
      logic [15:0] usage;
      logic [1:0]  kind;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         roll = $urandom_range(0, 99);
         page = HidPageKeyboard;
         if (roll < 45) begin
            kind  = ReportArray;
            usage = 16'($urandom_range(0, TableEntries - 1));
         end else if (roll < 70) begin
            kind  = ReportVariable;
            usage = ModFirst + 16'($urandom_range(0, 7));
         end else if (roll < 80) begin
            kind  = ReportVariable;
            usage = 16'($urandom_range(0, TableEntries - 1));
         end else begin
            if (roll >= 88) page = 16'($urandom);
            usage = 16'($urandom);
            kind  = 2'($urandom_range(0, 3));
         end
         send_event(page, usage, kind, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_output_stall();
      test_random_events(1100);
      req_valid <= 1'b0;
      while (expected_scan_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[hid_to_ps2_scancode_translator] OK");
      end else begin
         $display("[hid_to_ps2_scancode_translator] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side

   initial begin : rsp_throttle
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall_left = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                      : $urandom_range(8, 24);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : scan_beat_check
      scan_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scan_beats.size() == 0) begin
            $error("unexpected beat: event_kind %0b scan_byte %02h last %0b",
                   rsp_event_kind, rsp_scan_byte, rsp_last);
            error_count++;
         end else begin
            want = expected_scan_beats.pop_front();
            if (rsp_event_kind !== want.event_kind) begin
               $error("event_kind: expected %0b, actual %0b", want.event_kind, rsp_event_kind);
               error_count++;
            end
            if (rsp_scan_byte !== want.scan_byte) begin
               $error("scan_byte: expected %02h, actual %02h", want.scan_byte, rsp_scan_byte);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

endmodule
